FILE: design/nbcs_pkg.sv
// ----------------------------------------------------------------------------
// nbcs_pkg: shared types and constants of the contrast stretch
// Widths, register indexes, item codes and the structs that travel
// between the control, line buffer, lane and merge modules.
// ----------------------------------------------------------------------------
package nbcs_pkg;

  localparam int MAX_COLS = 2048;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 2);

  localparam int PIX_W = 8;
  localparam int NUM_CH = 3;
  localparam int WORD_W = PIX_W * NUM_CH;

  localparam int COLS_FIELD_W = 12;
  localparam int ROW_W = 16;
  localparam int STEP_W = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_AMOUNT = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_W = $clog2(OQ_DEPTH);
  localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_CH-1:0][PIX_W-1:0] pix3_t;

  typedef struct packed {
    logic take;
    logic [COL_W-1:0] col;
  } slot_t;

  typedef struct packed {
    logic emit;
    logic [COL_W-1:0] oc;
    logic [ROW_W-1:0] orow;
  } s1_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic frame_end;
  } tag_t;

  typedef struct packed {
    pix_t blue;
    pix_t green;
    pix_t red;
    logic frame_end;
  } res_t;

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

endpackage

FILE: design/nbcs_if.sv
// ----------------------------------------------------------------------------
// nbcs_if: channel interfaces of the contrast stretch
// Pixel input channel, pixel output channel and register write channel,
// each with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface nbcs_in_if;
  import nbcs_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] red_in;
  modport source (output valid, kind, blue_in, green_in, red_in, input ready);
  modport sink (input valid, kind, blue_in, green_in, red_in, output ready);
endinterface

interface nbcs_out_if;
  import nbcs_pkg::*;
  logic valid;
  logic ready;
  logic [PIX_W-1:0] blue_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] red_out;
  logic frame_end;
  modport source (output valid, blue_out, green_out, red_out, frame_end, input ready);
  modport sink (input valid, blue_out, green_out, red_out, frame_end, output ready);
endinterface

interface nbcs_cfg_if;
  import nbcs_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/nbcs_ctrl.sv
// ----------------------------------------------------------------------------
// nbcs_ctrl: registers, stream position and pending count
// Holds the configuration, tracks the raster position and the number of
// pending results, and tags each item with its center position.
// ----------------------------------------------------------------------------
module nbcs_ctrl (
  input  logic clk,
  input  logic rst,
  nbcs_cfg_if.sink cfg,
  input  logic fire,
  input  logic kind,
  output nbcs_pkg::slot_t slot,
  output logic s1_valid,
  output nbcs_pkg::s1_t s1,
  output logic [nbcs_pkg::CNT_W-1:0] cols,
  output logic [nbcs_pkg::ROW_W-1:0] rows,
  output logic [nbcs_pkg::STEP_W-1:0] step
);
  import nbcs_pkg::*;

  logic [COLS_FIELD_W-1:0] frame_cols;
  logic [ROW_W-1:0] frame_rows;
  logic [COL_W-1:0] column_count;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count;
  logic [ROW_W-1:0] row_count_next;
  logic [CNT_W-1:0] pending_count;
  logic [CNT_W-1:0] pending_count_next;

  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] pend;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [ROW_W:0] r_inc;
  logic [CNT_W-1:0] nc;
  logic [ROW_W:0] r2;
  logic [1:0] sub;
  logic emit;
  logic [ROW_W-1:0] s1_next_orow;
  logic [COL_W-1:0] s1_next_oc;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (frame_cols < COLS_FIELD_W'(3)) begin
      cols = CNT_W'(3);
    end else if (32'(frame_cols) > 32'(MAX_COLS)) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = CNT_W'(frame_cols);
    end
    rows = (frame_rows < ROW_W'(3)) ? ROW_W'(3) : frame_rows;
  end

  always_comb begin
    lim = cols + CNT_W'(1);
    pend = (pending_count > lim) ? lim : pending_count;
    slot.take = fire && !(kind == KIND_FLUSH && pend == '0);

    if (CNT_W'(column_count) >= cols) begin
      col = '0;
      r_inc = {1'b0, row_count} + (ROW_W+1)'(1);
    end else begin
      col = column_count;
      r_inc = {1'b0, row_count};
    end
    row = (r_inc >= {1'b0, rows}) ? '0 : r_inc[ROW_W-1:0];
    slot.col = col;

    sub = (col != '0) ? 2'd1 : 2'd2;
    if ({1'b0, row} >= (ROW_W+1)'(sub)) begin
      s1_next_orow = row - ROW_W'(sub);
    end else begin
      s1_next_orow = ROW_W'({1'b0, row} + {1'b0, rows} - (ROW_W+1)'(sub));
    end
    s1_next_oc = (col != '0) ? col - COL_W'(1) : COL_W'(cols - CNT_W'(1));

    nc = CNT_W'(col) + CNT_W'(1);
    r2 = {1'b0, row} + (ROW_W+1)'(1);
    if (nc >= cols) begin
      column_count_next = '0;
      row_count_next = (r2 >= {1'b0, rows}) ? '0 : r2[ROW_W-1:0];
    end else begin
      column_count_next = nc[COL_W-1:0];
      row_count_next = row;
    end

    if (kind == KIND_FLUSH) begin
      emit = 1'b1;
      pending_count_next = pend - CNT_W'(1);
      if (pending_count_next == '0) begin
        column_count_next = '0;
        row_count_next = '0;
      end
    end else begin
      emit = (pend >= lim);
      pending_count_next = emit ? lim : pend + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols <= COLS_FIELD_W'(640);
      frame_rows <= ROW_W'(480);
      step <= STEP_W'(1);
      column_count <= '0;
      row_count <= '0;
      pending_count <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_FRAME_COLS: frame_cols <= cfg.data[COLS_FIELD_W-1:0];
          CFG_FRAME_ROWS: frame_rows <= cfg.data[ROW_W-1:0];
          CFG_STEP_AMOUNT: step <= cfg.data[STEP_W-1:0];
          default: ;
        endcase
      end
      s1_valid <= slot.take;
      if (slot.take) begin
        column_count <= column_count_next;
        row_count <= row_count_next;
        pending_count <= pending_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot.take) begin
      s1.emit <= emit;
      s1.oc <= s1_next_oc;
      s1.orow <= s1_next_orow;
    end
  end

endmodule

FILE: design/nbcs_linebuf.sv
// ----------------------------------------------------------------------------
// nbcs_linebuf: upper and middle line buffers
// Reads both lines at the item's column and writes the new pixel to the
// middle line; the upper line takes the old middle value in the next cycle.
// ----------------------------------------------------------------------------
module nbcs_linebuf (
  input  logic clk,
  input  nbcs_pkg::slot_t slot,
  input  logic [nbcs_pkg::WORD_W-1:0] px,
  input  logic s1_valid,
  output logic [nbcs_pkg::WORD_W-1:0] up,
  output logic [nbcs_pkg::WORD_W-1:0] mid,
  output logic [nbcs_pkg::WORD_W-1:0] px_d
);
  import nbcs_pkg::*;

  logic [WORD_W-1:0] upper_line [MAX_COLS];
  logic [WORD_W-1:0] middle_line [MAX_COLS];
  logic [WORD_W-1:0] up_rd;
  logic [WORD_W-1:0] byp;
  logic [COL_W-1:0] col_d;
  logic hz;

  always_ff @(posedge clk) begin
    if (slot.take) begin
      mid <= middle_line[slot.col];
      middle_line[slot.col] <= px;
      px_d <= px;
      col_d <= slot.col;
      hz <= s1_valid && (col_d == slot.col);
      byp <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot.take) begin
      up_rd <= upper_line[slot.col];
    end
    if (s1_valid) begin
      upper_line[col_d] <= mid;
    end
  end

  assign up = hz ? byp : up_rd;

endmodule

FILE: design/nbcs_lane.sv
// ----------------------------------------------------------------------------
// nbcs_lane: one color channel of the stretch
// Keeps column minimum and maximum of the 3x3 window, reduces them to the
// window range, and decides the stretched value for the center pixel.
// ----------------------------------------------------------------------------
module nbcs_lane (
  input  logic clk,
  input  logic rst,
  input  logic en1,
  input  logic en2,
  input  nbcs_pkg::pix_t up,
  input  nbcs_pkg::pix_t mid,
  input  nbcs_pkg::pix_t px,
  input  logic [nbcs_pkg::STEP_W-1:0] step,
  output nbcs_pkg::pix_t res,
  output nbcs_pkg::pix_t ctr
);
  import nbcs_pkg::*;

  pix_t mn0, mn1, mn2;
  pix_t mx0, mx1, mx2;
  pix_t md1, md2;
  pix_t lo, hi, p;
  pix_t span;
  logic [PIX_W:0] twice;
  logic [PIX_W:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      mn0 <= '0;
      mn1 <= '0;
      mn2 <= '0;
      mx0 <= '0;
      mx1 <= '0;
      mx2 <= '0;
      md1 <= '0;
      md2 <= '0;
    end else if (en1) begin
      mn0 <= mn1;
      mn1 <= mn2;
      mn2 <= min3(up, mid, px);
      mx0 <= mx1;
      mx1 <= mx2;
      mx2 <= max3(up, mid, px);
      md1 <= md2;
      md2 <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      lo <= min3(mn0, mn1, mn2);
      hi <= max3(mx0, mx1, mx2);
      p <= md1;
    end
  end

  always_comb begin
    span = hi - lo;
    twice = {p - lo, 1'b0};
    sum = {1'b0, p} + {1'b0, step};
    if (lo == hi) begin
      res = lo;
    end else if (twice < {1'b0, span}) begin
      res = (p > step) ? p - step : '0;
    end else if (twice > {1'b0, span}) begin
      res = (sum < (PIX_W+1)'(255)) ? sum[PIX_W-1:0] : PIX_W'(255);
    end else begin
      res = p;
    end
  end

  assign ctr = p;

endmodule

FILE: design/nbcs_merge.sv
// ----------------------------------------------------------------------------
// nbcs_merge: merge of the lane results and output queue
// Picks stretched or original channels per border flag, joins the frame
// end mark and queues the pixel for the output channel.
// ----------------------------------------------------------------------------
module nbcs_merge (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  nbcs_pkg::tag_t tag,
  input  nbcs_pkg::pix3_t res,
  input  nbcs_pkg::pix3_t ctr,
  nbcs_out_if.source pix_out,
  output logic [nbcs_pkg::OQ_CW-1:0] count
);
  import nbcs_pkg::*;

  res_t oq [OQ_DEPTH];
  res_t wr_data;
  res_t head;
  logic [OQ_W-1:0] wr_ptr;
  logic [OQ_W-1:0] rd_ptr;
  logic pop;

  always_comb begin
    wr_data.blue = tag.border ? ctr[0] : res[0];
    wr_data.green = tag.border ? ctr[1] : res[1];
    wr_data.red = tag.border ? ctr[2] : res[2];
    wr_data.frame_end = tag.frame_end;
  end

  assign pop = pix_out.valid && pix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OQ_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_W'(1);
      end
      count <= count + OQ_CW'(push) - OQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq[wr_ptr] <= wr_data;
    end
  end

  assign head = oq[rd_ptr];
  assign pix_out.valid = (count != '0);
  assign pix_out.blue_out = head.blue;
  assign pix_out.green_out = head.green;
  assign pix_out.red_out = head.red;
  assign pix_out.frame_end = head.frame_end;

endmodule

FILE: design/neighborhood_contrast_stretch.sv
// ----------------------------------------------------------------------------
// neighborhood_contrast_stretch: 3x3 local min/max contrast stretch
// RGB raster stream in, each pixel out one row plus one pixel later with
// border pixels passed through and interior channels stretched.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload
//   pix_in    in         kind, blue_in, green_in, red_in
//   pix_out   out        blue_out, green_out, red_out, frame_end
//   cfg       in         index, data (always ready)
//
// One item is taken per cycle while input ready is high; a result passes the line
// buffer read, the lane column stage and the range stage before it is written to
// the output queue, and can leave in the next cycle.
// Reset clears position, pending count, window and queue; the line buffers
// are not cleared and take items right away.
// Input ready drops only when the eight-entry output queue together with
// the results in flight is full.
module neighborhood_contrast_stretch (
  input  logic clk,
  input  logic rst,
  nbcs_in_if.sink pix_in,
  nbcs_out_if.source pix_out,
  nbcs_cfg_if.sink cfg
);
  import nbcs_pkg::*;

  slot_t slot;
  logic s1_valid;
  s1_t s1;
  logic [CNT_W-1:0] cols;
  logic [ROW_W-1:0] rows;
  logic [STEP_W-1:0] step;
  logic fire;
  logic [WORD_W-1:0] px;
  logic [WORD_W-1:0] up;
  logic [WORD_W-1:0] mid;
  logic [WORD_W-1:0] px_d;
  tag_t s1_tag;
  logic s2_valid;
  tag_t s2_tag;
  logic s3_valid;
  tag_t s3_tag;
  pix3_t res;
  pix3_t ctr;
  logic [OQ_CW-1:0] oq_count;
  logic [OQ_CW:0] busy;

  assign busy = (OQ_CW+1)'(oq_count) + (OQ_CW+1)'(s1_valid && s1.emit)
              + (OQ_CW+1)'(s2_valid && s2_tag.emit) + (OQ_CW+1)'(s3_valid && s3_tag.emit);
  assign pix_in.ready = (busy < (OQ_CW+1)'(OQ_DEPTH));
  assign fire = pix_in.valid && pix_in.ready;
  assign px = (pix_in.kind == KIND_FLUSH) ? '0
            : {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

  nbcs_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .fire(fire),
    .kind(pix_in.kind),
    .slot(slot),
    .s1_valid(s1_valid),
    .s1(s1),
    .cols(cols),
    .rows(rows),
    .step(step)
  );

  nbcs_linebuf u_linebuf (
    .clk(clk),
    .slot(slot),
    .px(px),
    .s1_valid(s1_valid),
    .up(up),
    .mid(mid),
    .px_d(px_d)
  );

  always_comb begin
    s1_tag.emit = s1.emit;
    s1_tag.border = (s1.orow == '0) || (s1.orow >= rows - ROW_W'(1)) || (s1.oc == '0)
                  || (CNT_W'(s1.oc) >= cols - CNT_W'(1));
    s1_tag.frame_end = (s1.orow == rows - ROW_W'(1)) && (CNT_W'(s1.oc) == cols - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_tag <= s1_tag;
    end
    if (s2_valid) begin
      s3_tag <= s2_tag;
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    nbcs_lane u_lane (
      .clk(clk),
      .rst(rst),
      .en1(s1_valid),
      .en2(s2_valid),
      .up(up[ch*PIX_W +: PIX_W]),
      .mid(mid[ch*PIX_W +: PIX_W]),
      .px(px_d[ch*PIX_W +: PIX_W]),
      .step(step),
      .res(res[ch]),
      .ctr(ctr[ch])
    );
  end

  nbcs_merge u_merge (
    .clk(clk),
    .rst(rst),
    .push(s3_valid && s3_tag.emit),
    .tag(s3_tag),
    .res(res),
    .ctr(ctr),
    .pix_out(pix_out),
    .count(oq_count)
  );

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    busy <= (OQ_CW+1)'(OQ_DEPTH))
    else $error("output queue and results in flight exceed the queue depth");

  a_frame_end_border: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_tag.frame_end |-> s2_tag.border)
    else $error("frame end marked on an interior pixel");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !pix_out.valid)
    else $error("output valid right after reset");

endmodule
